// ----- rtl/nfa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nfa_pkg: shared types and constants of the NFA stream matcher
// Field widths, command codes, register indexes and the request structs
// that travel between the matcher's modules.
// ----------------------------------------------------------------------------
package nfa_pkg;

    // Fixed field widths.
    localparam int SET_W    = 16;
    localparam int STATE_W  = 4;
    localparam int CMD_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam int MAX_STATES = 16;

    // Default number of NFA states.
    localparam int NUM_STATES_DEF = 16;

    // Item kinds carried on tuser.
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_START  = 2'd1,
        CMD_SYMBOL = 2'd2
    } nfa_cmd_t;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_STATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FINAL_MASK    = 1'b1;

    // Row write broadcast to every cell.
    typedef struct packed {
        logic               en;
        logic [STATE_W-1:0] state;
        logic               symbol;
        logic [SET_W-1:0]   mask;
    } nfa_load_t;

    // One result item.
    typedef struct packed {
        logic             accepted;
        logic [SET_W-1:0] active_set;
    } nfa_result_t;

endpackage
`default_nettype wire

// ----- rtl/nfa_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nfa_cell: one NFA state of the matcher chain
// Holds both transition rows of its state and adds its row for the current
// symbol to the running next-set OR when its state is active.
// ----------------------------------------------------------------------------
module nfa_cell
    import nfa_pkg::*;
#(
    parameter int CELL_INDEX = 0
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire nfa_load_t        load,
    input  wire logic             active,
    input  wire logic             symbol,
    input  wire logic [SET_W-1:0] or_in,
    output logic      [SET_W-1:0] or_out
);

    localparam logic [STATE_W-1:0] MY_STATE = STATE_W'(CELL_INDEX);

    logic [SET_W-1:0] row0_reg;
    logic [SET_W-1:0] row1_reg;
    logic             wr_hit;

    assign wr_hit = load.en && (load.state == MY_STATE);

    // Transition rows; the store is cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row0_reg <= '0;
            row1_reg <= '0;
        end
        else if (wr_hit)
        begin
            if (load.symbol)
            begin
                row1_reg <= load.mask;
            end
            else
            begin
                row0_reg <= load.mask;
            end
        end
    end

    // Add this state's row to the partial next set from the left neighbor.
    always_comb
    begin
        or_out = or_in;
        if (active)
        begin
            or_out = or_in | (symbol ? row1_reg : row0_reg);
        end
    end

endmodule
`default_nettype wire

// ----- rtl/nfa_out_buf.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nfa_out_buf: result register with skid stage
// Holds up to two results so the input side keeps taking requests while
// the downstream side stalls, until both slots are full.
// ----------------------------------------------------------------------------
module nfa_out_buf
    import nfa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire nfa_result_t push_data,
    output logic             push_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    output nfa_result_t      out_data
);

    logic        out_valid_reg;
    logic        out_valid_next;
    nfa_result_t out_data_reg;
    nfa_result_t out_data_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    nfa_result_t skid_data_reg;
    nfa_result_t skid_data_next;
    logic        out_free;

    assign out_free   = !out_valid_reg || out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    // Next-state logic: refill the output slot from the skid first.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    // Control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule
`default_nettype wire

// ----- rtl/nfa_subset_stream_matcher_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nfa_subset_stream_matcher_unit: bit-parallel NFA matcher over a stream
// Tracks the active states of a binary-alphabet NFA, one request a cycle if ready.
// ----------------------------------------------------------------------------
// The block takes one request per cycle unless stalled and returns one result
// per request in request order; the result is offered in the cycle after the
// request is accepted, later only while the result stream stalls. Each request
// is a row load, a start of a new string, or one input symbol. Every state
// is a cell in a chain that holds its two transition rows; a symbol request
// forms the next set in the same cycle by ORing the rows of active states
// along the chain, so the chain depth (NUM_STATES, capped at 16) sets the
// critical path and not the throughput. A two-entry output buffer keeps the
// input open while a result waits; input ready drops only when two results
// are pending. The transition store is cleared by reset with no sweep. The user
// must write registers via the cfg port only while idle; this is not enforced.
// ----------------------------------------------------------------------------
module nfa_subset_stream_matcher_unit
    import nfa_pkg::*;
#(
    parameter int NUM_STATES = NUM_STATES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write port.
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Request stream.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [3:0] row_state, [4] row_symbol, [20:5] row_mask, [21] symbol, [23:22] zero
    input  wire logic [23:0]           s_tdata,
    // [1:0] cmd
    input  wire logic [CMD_W-1:0]      s_tuser,
    // Result stream.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [15:0] active_set, [16] accepted, [23:17] zero
    output logic [23:0]                m_tdata
);

    localparam int NUM_CELLS = (NUM_STATES >= MAX_STATES) ? MAX_STATES : NUM_STATES;
    localparam logic [SET_W-1:0] VALID_MASK = (NUM_CELLS >= SET_W) ? {SET_W{1'b1}}
        : SET_W'((17'd1 << NUM_CELLS) - 17'd1);

    logic [STATE_W-1:0] initial_state_reg;
    logic [SET_W-1:0]   final_mask_reg;
    logic [SET_W-1:0]   current_set_reg;
    logic [SET_W-1:0]   current_set_next;
    logic [SET_W-1:0]   start_set;
    logic [SET_W-1:0]   or_chain [NUM_CELLS+1];
    logic               in_acc;
    nfa_cmd_t           cmd;
    nfa_load_t          load;
    nfa_result_t        result;
    nfa_result_t        out_data;

    assign in_acc = s_tvalid && s_tready;
    assign cmd    = nfa_cmd_t'(s_tuser);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_state_reg <= '0;
            final_mask_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_INITIAL_STATE: initial_state_reg <= cfg_data[STATE_W-1:0];
                CFG_FINAL_MASK:    final_mask_reg    <= cfg_data[SET_W-1:0];
            endcase
        end
    end

    // Row write broadcast to the cells.
    assign load.en     = in_acc && (cmd == CMD_LOAD);
    assign load.state  = s_tdata[3:0];
    assign load.symbol = s_tdata[4];
    assign load.mask   = s_tdata[20:5] & VALID_MASK;

    // Chain of state cells forming the next-set OR.
    assign or_chain[0] = '0;
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        nfa_cell #(
            .CELL_INDEX(i)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .load   (load),
            .active (current_set_reg[i]),
            .symbol (s_tdata[21]),
            .or_in  (or_chain[i]),
            .or_out (or_chain[i+1])
        );
    end

    // Single start state, empty when the index names no state.
    assign start_set = (int'(initial_state_reg) < NUM_CELLS)
        ? (SET_W'(1) << initial_state_reg) : '0;

    // Active set after the current request.
    always_comb
    begin
        current_set_next = current_set_reg;
        unique case (cmd)
            CMD_LOAD:   current_set_next = current_set_reg;
            CMD_START:  current_set_next = start_set;
            CMD_SYMBOL: current_set_next = or_chain[NUM_CELLS] & VALID_MASK;
            default:    current_set_next = current_set_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_set_reg <= SET_W'(1) & VALID_MASK;
        end
        else if (in_acc)
        begin
            current_set_reg <= current_set_next;
        end
    end

    // Result of this request.
    assign result.active_set = current_set_next;
    assign result.accepted   = |(current_set_next & final_mask_reg);

    nfa_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_acc),
        .push_data  (result),
        .push_ready (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data)
    );

    assign m_tdata = {7'd0, out_data.accepted, out_data.active_set};

`ifndef SYNTHESIS
    // No state beyond the configured count ever becomes active.
    a_set_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (current_set_reg & ~VALID_MASK) == '0)
        else $error("active set holds a nonexistent state");

    // A start request leaves at most one active state.
    a_start_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && cmd == CMD_START) |=> $onehot0(current_set_reg))
        else $error("start request left more than one active state");

    // An empty set is never reported as accepted.
    a_accept_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[16] && m_tdata[15:0] == '0))
        else $error("empty active set reported as accepted");

    // A load request does not change the active set.
    a_load_keeps_set: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && cmd == CMD_LOAD) |=> $stable(current_set_reg))
        else $error("load request changed the active set");
`endif

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the NFA stream matcher
// Drives row loads, string starts and symbols into the request stream with
// bursty timing, stalls the result stream, and checks every result against
// a bit-level tracker of the transition rows and the active-state set.
// ----------------------------------------------------------------------------
module tb_top;
    import nfa_pkg::*;

    // The fourth command code is unused by the block and must change nothing.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Mask of states that exist in the default build.
    localparam logic [SET_W-1:0] VALID_STATES =
        (NUM_STATES_DEF >= 16) ? 16'hFFFF : SET_W'((1 << NUM_STATES_DEF) - 1);

    // Cycles with no request or result moving before the run is abandoned.
    localparam int STALL_LIMIT = 4000;
    // Length of the long result hold-off.
    localparam int LONG_HOLD = 300;

    // Tracks transition rows and the active set, and queues the due results.
    class active_set_tracker;
        logic [SET_W-1:0]   rows [32];
        logic [SET_W-1:0]   active;
        logic [STATE_W-1:0] init_state;
        logic [SET_W-1:0]   accept_mask;
        nfa_result_t        due_results [$];
        int unsigned        errors;

        function logic [SET_W-1:0] start_set();
            logic [SET_W-1:0] one_hot;
            one_hot = SET_W'(1) << init_state;
            return one_hot & VALID_STATES;
        endfunction

        function void clear();
            foreach (rows[i]) rows[i] = '0;
            init_state  = '0;
            accept_mask = '0;
            active      = start_set();
            due_results.delete();
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_INITIAL_STATE)
                init_state = data[STATE_W-1:0];
            else
                accept_mask = data;
        endfunction

        // Advance the tracker by one accepted request and queue its result.
        function void note_request(logic [CMD_W-1:0] cmd, logic [23:0] data);
            logic [STATE_W-1:0] row_state;
            logic               row_symbol;
            logic [SET_W-1:0]   row_mask;
            logic               symbol;
            logic [SET_W-1:0]   next_set;
            nfa_result_t        res;
            row_state  = data[3:0];
            row_symbol = data[4];
            row_mask   = data[20:5];
            symbol     = data[21];
            case (cmd)
                CMD_LOAD:
                    rows[{row_state, row_symbol}] = row_mask & VALID_STATES;
                CMD_START:
                    active = start_set();
                CMD_SYMBOL:
                begin
                    next_set = '0;
                    for (int s = 0; s < MAX_STATES; s++)
                        if (active[s])
                            next_set |= rows[{STATE_W'(s), symbol}];
                    active = next_set & VALID_STATES;
                end
                default:
                    ;
            endcase
            res.active_set = active;
            res.accepted   = |(active & accept_mask);
            due_results.push_back(res);
        endfunction

        // Compare one result with the oldest one due.
        function void check_result(logic [23:0] data);
            nfa_result_t want;
            if (due_results.size() == 0) begin
                $error("unexpected result: active_set=%h accepted=%b",
                       data[15:0], data[16]);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (data[15:0] !== want.active_set) begin
                $error("active_set: expected %h, got %h", want.active_set, data[15:0]);
                errors++;
            end
            if (data[16] !== want.accepted) begin
                $error("accepted: expected %b, got %b", want.accepted, data[16]);
                errors++;
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [23:0]           s_tdata;
    logic [CMD_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [23:0]           m_tdata;

    active_set_tracker tracker;

    int idle_cycles;
    int burst_left;
    int rx_run_left;
    int rx_stall_left;
    int rx_hold_left;
    logic long_hold_req;

    nfa_subset_stream_matcher_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock generator.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Monitor both streams at the rising edge and keep the watchdog.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_tvalid && s_tready)
                tracker.note_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                tracker.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Result receiver: runs and stalls of random length, plus one long hold-off.
    always @(negedge clk)
    begin
        if (rx_hold_left > 0) begin
            m_tready <= 1'b0;
            rx_hold_left--;
        end else if (long_hold_req) begin
            m_tready      <= 1'b0;
            rx_hold_left  = LONG_HOLD;
            long_hold_req <= 1'b0;
        end else if (rx_run_left > 0) begin
            m_tready <= 1'b1;
            rx_run_left--;
        end else if (rx_stall_left > 0) begin
            m_tready <= 1'b0;
            rx_stall_left--;
        end else begin
            m_tready      <= 1'b1;
            rx_run_left   = $urandom_range(0, 30);
            rx_stall_left = $urandom_range(0, 6);
        end
    end

    function automatic logic [23:0] pack_request(logic [STATE_W-1:0] row_state,
                                                 logic row_symbol,
                                                 logic [SET_W-1:0] row_mask,
                                                 logic symbol);
        return {2'b00, symbol, row_mask, row_symbol, row_state};
    endfunction

    // Mostly sparse masks, so active sets neither die out nor fill up at once.
    function automatic logic [SET_W-1:0] sparse_mask();
        logic [SET_W-1:0] m;
        case ($urandom_range(0, 3))
            0: m = SET_W'(1) << $urandom_range(0, 15);
            1: m = (SET_W'(1) << $urandom_range(0, 15)) | (SET_W'(1) << $urandom_range(0, 15));
            2: m = SET_W'($urandom & $urandom & $urandom);
            default: m = SET_W'($urandom);
        endcase
        return m;
    endfunction

    // Offer one request at the falling edge and hold it until accepted.
    task automatic send_request(logic [CMD_W-1:0] cmd, logic [23:0] data);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        if (burst_left == 0) begin
            gap        = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            s_tvalid  <= 1'b0;
            repeat (gap) @(negedge clk);
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_load(logic [STATE_W-1:0] st, logic sym, logic [SET_W-1:0] mask);
        send_request(CMD_LOAD, pack_request(st, sym, mask, 1'($urandom)));
    endtask

    // Start and symbol requests carry random bits in the fields they ignore.
    task automatic send_start();
        send_request(CMD_START, pack_request(STATE_W'($urandom), 1'($urandom),
                                             SET_W'($urandom), 1'($urandom)));
    endtask

    task automatic send_symbol(logic sym);
        send_request(CMD_SYMBOL, pack_request(STATE_W'($urandom), 1'($urandom),
                                              SET_W'($urandom), sym));
    endtask

    task automatic send_noise();
        send_request(CMD_W'($urandom_range(0, 3)), {2'b00, 22'($urandom)});
    endtask

    // Stop offering and wait until every due result has arrived.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write both registers back to back; the block is idle here.
    task automatic program_registers(logic [STATE_W-1:0] init, logic [SET_W-1:0] fin);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_INITIAL_STATE;
        cfg_data  <= {12'b0, init};
        tracker.write_reg(CFG_INITIAL_STATE, {12'b0, init});
        @(negedge clk);
        cfg_index <= CFG_FINAL_MASK;
        cfg_data  <= fin;
        tracker.write_reg(CFG_FINAL_MASK, fin);
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // One random phase: mostly well-formed strings, some noise.
    task automatic run_phase(int count);
        int sent;
        int n;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 75) begin
                n = $urandom_range(0, 3);
                repeat (n) send_load(STATE_W'($urandom), 1'($urandom), sparse_mask());
                send_start();
                sent += n + 1;
                n = $urandom_range(1, 12);
                repeat (n) send_symbol(1'($urandom));
                sent += n;
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) send_noise();
                sent += n;
            end
        end
    endtask

    // Main sequence.
    initial
    begin
        logic [STATE_W-1:0] init_list [8];
        logic [SET_W-1:0]   final_list [8];

        tracker       = new();
        tracker.clear();
        idle_cycles   = 0;
        burst_left    = 10;
        rx_run_left   = 0;
        rx_stall_left = 0;
        rx_hold_left  = 0;
        long_hold_req = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = CMD_LOAD;
        m_tready      = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. A symbol straight after reset sees only cleared rows.
        send_symbol(1'b1);
        send_start();
        drain();
        program_registers(4'd0, 16'h8000);
        send_load(4'd0, 1'b0, 16'h0001);
        send_load(4'd0, 1'b1, 16'h0003);
        send_load(4'd1, 1'b1, 16'h8000);
        send_load(4'd15, 1'b0, 16'hFFFF);
        send_load(4'd15, 1'b1, 16'h8000);
        send_start();
        send_symbol(1'b1);
        send_symbol(1'b1);
        // The unused command and a load both leave the active set alone.
        send_request(CMD_UNUSED, 24'h3FFFFF);
        send_load(4'd7, 1'b0, 16'h0000);
        send_symbol(1'b0);
        send_symbol(1'b1);
        send_symbol(1'b0);
        send_load(4'd1, 1'b0, 16'h0000);
        send_request(CMD_UNUSED, 24'h000000);
        drain();
        // Highest start state, and every state accepting.
        program_registers(4'd15, 16'hFFFF);
        send_start();
        send_symbol(1'b1);
        send_symbol(1'b0);
        send_load(4'd15, 1'b0, 16'h0000);
        send_symbol(1'b0);
        send_start();
        send_symbol(1'b1);
        drain();

        // Random phases over a spread of register settings.
        init_list[0] = 4'd0;             final_list[0] = 16'hFFFF;
        init_list[1] = 4'd15;            final_list[1] = 16'h0001;
        init_list[2] = STATE_W'($urandom); final_list[2] = 16'h0000;
        for (int p = 3; p < 8; p++) begin
            init_list[p]  = STATE_W'($urandom);
            final_list[p] = sparse_mask();
        end
        for (int p = 0; p < 8; p++) begin
            program_registers(init_list[p], final_list[p]);
            // One phase holds results back so the block fills and stalls its input.
            if (p == 3)
                long_hold_req <= 1'b1;
            run_phase(200);
            drain();
        end

        repeat (10) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
